[design/lcpef_pkg.sv]
// Shared types, constants and helpers for the Lennard-Jones pair energy/force block.
package lcpef_pkg;

    localparam int DIST_W     = 32;
    localparam int EPS_W      = 32;
    localparam int RM6_W      = 40;
    localparam int OUT_W      = 48;
    localparam int CFG_W      = 40;
    localparam int CFG_IDX_W  = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int SQRT_STEPS = 32;
    localparam int TDIV_STEPS = 64;
    localparam int FDIV_STEPS = 48;

    // Back-end stage map, counted from the register that takes the queue head
    localparam int ST_TDIV    = 3;
    localparam int ST_T       = ST_TDIV + TDIV_STEPS;
    localparam int ST_FDIV    = ST_T + 6;
    localparam int ST_LAST    = ST_FDIV + FDIV_STEPS;
    localparam int PIPE_DEPTH = ST_LAST + 1;
    localparam int LATENCY    = ST_LAST + 3;

    localparam logic [63:0]    T_ONE   = 64'h1_0000_0000;
    localparam logic [63:0]    T_TWO   = 64'h2_0000_0000;
    localparam logic [OUT_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CLS_CUT,
        CLS_ZERO,
        CLS_NORM
    } t_cls;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ,
        CFG_EPS_AA,
        CFG_EPS_AB,
        CFG_EPS_BB,
        CFG_RMSIX_AA,
        CFG_RMSIX_AB,
        CFG_RMSIX_BB
    } t_cfg_idx;

    typedef struct packed {
        logic              wf;
        t_cls              cls;
        logic [EPS_W-1:0]  eps;
        logic [RM6_W-1:0]  rm6;
        logic [DIST_W-1:0] dq;
    } t_job;

    typedef struct packed {
        t_job              job;
        logic [31:0]       s;
        logic              ovf;
        logic [63:0]       mage;
        logic              nege;
        logic [63:0]       magf;
        logic              negf;
        logic [OUT_W-1:0]  energy;
        logic              esat;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic [OUT_W-1:0] v;
        logic             sat;
    } t_packed;

    // Clip a magnitude to the signed 48-bit range and apply the sign
    function automatic t_packed pack48(input logic [95:0] mag, input logic neg);
        t_packed          r;
        logic [95:0]      lim;
        logic [OUT_W-1:0] v;
        lim   = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
        r.sat = mag > lim;
        v     = r.sat ? lim[OUT_W-1:0] : mag[OUT_W-1:0];
        r.v   = neg ? OUT_W'(~v + 1'b1) : v;
        return r;
    endfunction

endpackage

[design/lj_cut_pair_energy_force_top.sv]
// Top level of the Lennard-Jones 12-6 cutoff pair energy and force unit.
//
//  channel  | transfer when           | carries
//  ---------+-------------------------+------------------------------------------
//  config   | i_cfg_we                | i_cfg_idx, i_cfg_data
//  input    | start && !busy          | i_first_type, i_second_type, i_dist_sq,
//           |                         | i_want_force
//  result   | o_done (one cycle)      | o_energy, o_force_res, o_force_valid,
//           |                         | o_saturated
//
// One pair per cycle, sustained. Each accepted start comes back as an o_done
// strobe; the 64-step ratio divider and the 48-step force divider make up
// most of the pipeline between the two.
// Synchronous active-low reset clears the queue and the pipeline valid line
// and loads the register defaults. Results cannot be held off, and the back
// end drains the queue every cycle, so busy stays low in normal use.
module lj_cut_pair_energy_force_top import lcpef_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_first_type,
    input  logic                    i_second_type,
    input  logic [DIST_W-1:0]       i_dist_sq,
    input  logic                    i_want_force,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_energy,
    output logic signed [OUT_W-1:0] o_force_res,
    output logic                    o_force_valid,
    output logic                    o_saturated
);

    t_job       job_in, job_head;
    t_fifo_stat stat;
    logic       push, pop;

    assign busy = stat.full;
    assign push = start && !busy;
    assign pop  = !stat.empty;

    lcpef_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_first_type  (i_first_type),
        .i_second_type (i_second_type),
        .i_dist_sq     (i_dist_sq),
        .i_want_force  (i_want_force),
        .o_job         (job_in)
    );

    lcpef_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_stat  (stat)
    );

    lcpef_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop         (pop),
        .i_job         (job_head),
        .o_done        (o_done),
        .o_energy      (o_energy),
        .o_force_res   (o_force_res),
        .o_force_valid (o_force_valid),
        .o_saturated   (o_saturated)
    );

endmodule

[design/lcpef_front.sv]
// Front end: parameter registers, pair selection and cutoff/zero classification.
module lcpef_front import lcpef_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_first_type,
    input  logic                 i_second_type,
    input  logic [DIST_W-1:0]    i_dist_sq,
    input  logic                 i_want_force,
    output t_job                 o_job
);

    logic [DIST_W-1:0] r_cutoff_sq;
    logic [EPS_W-1:0]  r_eps_aa, r_eps_ab, r_eps_bb;
    logic [RM6_W-1:0]  r_rmsix_aa, r_rmsix_ab, r_rmsix_bb;
    logic [1:0]        pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq <= '1;
            r_eps_aa    <= 32'd65536;
            r_eps_ab    <= 32'd65536;
            r_eps_bb    <= 32'd65536;
            r_rmsix_aa  <= 40'd65536;
            r_rmsix_ab  <= 40'd65536;
            r_rmsix_bb  <= 40'd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CUTOFF_SQ: r_cutoff_sq <= i_cfg_data[DIST_W-1:0];
                CFG_EPS_AA:    r_eps_aa    <= i_cfg_data[EPS_W-1:0];
                CFG_EPS_AB:    r_eps_ab    <= i_cfg_data[EPS_W-1:0];
                CFG_EPS_BB:    r_eps_bb    <= i_cfg_data[EPS_W-1:0];
                CFG_RMSIX_AA:  r_rmsix_aa  <= i_cfg_data[RM6_W-1:0];
                CFG_RMSIX_AB:  r_rmsix_ab  <= i_cfg_data[RM6_W-1:0];
                CFG_RMSIX_BB:  r_rmsix_bb  <= i_cfg_data[RM6_W-1:0];
                default: ;
            endcase
        end
    end

    assign pair = {1'b0, i_first_type} + {1'b0, i_second_type};

    always_comb begin
        o_job.wf = i_want_force;
        o_job.dq = i_dist_sq;
        case (pair)
            2'd0: begin
                o_job.eps = r_eps_aa;
                o_job.rm6 = r_rmsix_aa;
            end
            2'd1: begin
                o_job.eps = r_eps_ab;
                o_job.rm6 = r_rmsix_ab;
            end
            default: begin
                o_job.eps = r_eps_bb;
                o_job.rm6 = r_rmsix_bb;
            end
        endcase
        // beyond cutoff wins over zero distance
        if (i_dist_sq > r_cutoff_sq) begin
            o_job.cls = CLS_CUT;
        end else if (i_dist_sq == '0) begin
            o_job.cls = CLS_ZERO;
        end else begin
            o_job.cls = CLS_NORM;
        end
    end

endmodule

[design/lcpef_fifo.sv]
// Short job queue between the front end and the arithmetic back end.
module lcpef_fifo import lcpef_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_head,
    output t_fifo_stat o_stat
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  push_ok, pop_ok;

    assign o_stat.full  = r_cnt == FIFO_CNT_W'(FIFO_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/lcpef_back.sv]
// Back end: pipelined cube, ratio divider, square root, products and force divider.
module lcpef_back import lcpef_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pop,
    input  t_job                    i_job,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_energy,
    output logic signed [OUT_W-1:0] o_force_res,
    output logic                    o_force_valid,
    output logic                    o_saturated
);

    t_item                  r_m [PIPE_DEPTH], n_m [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0]  r_v;

    logic [63:0]  r_dsq, r_p0, r_p1;
    logic [95:0]  r_d3;

    logic [35:0]  r_srem [SQRT_STEPS],  n_srem [SQRT_STEPS];
    logic [31:0]  r_sroot [SQRT_STEPS], n_sroot [SQRT_STEPS];

    logic [95:0]  r_trem [TDIV_STEPS], n_trem [TDIV_STEPS];
    logic [95:0]  r_td [TDIV_STEPS],   n_td [TDIV_STEPS];
    logic [63:0]  r_tq [TDIV_STEPS],   n_tq [TDIV_STEPS];
    logic         r_tovf [TDIV_STEPS], n_tovf [TDIV_STEPS];

    logic [63:0]  t_val, mage, magf;
    logic         nege, negf;
    logic [63:0]  r_e0, r_e1;
    logic [95:0]  r_pt;
    logic [63:0]  r_pe [3][2], r_pf [3][2], n_pe [3][2], n_pf [3][2];
    logic [127:0] r_re [2], r_rf [2];
    logic [159:0] r_ez, r_z;
    logic [163:0] z12;
    logic [123:0] r_y;
    t_packed      epk;

    logic [31:0]  r_frem [FDIV_STEPS], n_frem [FDIV_STEPS];
    logic [47:0]  r_flow [FDIV_STEPS], n_flow [FDIV_STEPS];
    logic [47:0]  r_fq [FDIV_STEPS],   n_fq [FDIV_STEPS];
    logic         r_fbig [FDIV_STEPS], n_fbig [FDIV_STEPS];

    t_item            fin;
    t_packed          fpk;
    logic [OUT_W-1:0] n_energy, n_force;
    logic             n_sat;

    // Item valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_pop};
        end
    end

    // Item side data, with fields filled in as the arithmetic finishes them
    always_comb begin
        n_m[0] = '{job: i_job, default: '0};
        for (int s = 1; s < PIPE_DEPTH; s++) begin
            n_m[s] = r_m[s-1];
        end
        n_m[SQRT_STEPS+1].s = r_sroot[SQRT_STEPS-1];
        n_m[ST_T+1].ovf     = r_tovf[TDIV_STEPS-1];
        n_m[ST_T+1].mage    = mage;
        n_m[ST_T+1].nege    = nege;
        n_m[ST_T+1].magf    = magf;
        n_m[ST_T+1].negf    = negf;
        n_m[ST_FDIV].energy = epk.v;
        n_m[ST_FDIV].esat   = epk.sat;
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    // Cube of the squared distance, cut into 32x32 partial products
    always_ff @(posedge i_clk) begin
        r_dsq <= {32'b0, r_m[0].job.dq} * {32'b0, r_m[0].job.dq};
        r_p0  <= {32'b0, r_dsq[31:0]} * {32'b0, r_m[1].job.dq};
        r_p1  <= {32'b0, r_dsq[63:32]} * {32'b0, r_m[1].job.dq};
        r_d3  <= {32'b0, r_p0} + {r_p1, 32'b0};
    end

    // Square root of dist_sq in Q.24, one result bit per stage
    always_comb begin : sqrt_rows
        logic [35:0] rem_in, r2, trial;
        logic [31:0] root_in;
        logic [63:0] x;
        logic        ge;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
            end else begin
                rem_in  = r_srem[k-1];
                root_in = r_sroot[k-1];
            end
            x           = {r_m[k].job.dq, 32'b0};
            r2          = {rem_in[33:0], x[63-2*k -: 2]};
            trial       = {2'b00, root_in, 2'b01};
            ge          = r2 >= trial;
            n_srem[k]   = ge ? r2 - trial : r2;
            n_sroot[k]  = {root_in[30:0], ge};
        end
    end

    // Ratio rm6 * 2^64 / d^3, one quotient bit per stage
    always_comb begin : tdiv_rows
        logic [95:0] rem_in, d_in;
        logic [63:0] q_in;
        logic [96:0] r2, dd;
        logic        ge, ovf_in;
        for (int k = 0; k < TDIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in = {56'b0, r_m[ST_TDIV].job.rm6};
                d_in   = r_d3;
                q_in   = '0;
                ovf_in = rem_in >= r_d3;
            end else begin
                rem_in = r_trem[k-1];
                d_in   = r_td[k-1];
                q_in   = r_tq[k-1];
                ovf_in = r_tovf[k-1];
            end
            dd        = {1'b0, d_in};
            r2        = {rem_in, 1'b0};
            ge        = r2 >= dd;
            n_trem[k] = ge ? 96'(r2 - dd) : r2[95:0];
            n_td[k]   = d_in;
            n_tq[k]   = {q_in[62:0], ge};
            n_tovf[k] = ovf_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srem  <= n_srem;
        r_sroot <= n_sroot;
        r_trem  <= n_trem;
        r_td    <= n_td;
        r_tq    <= n_tq;
        r_tovf  <= n_tovf;
    end

    // Distances of t from 2 and from 1
    assign t_val = r_tq[TDIV_STEPS-1];
    assign nege  = t_val < T_TWO;
    assign negf  = t_val < T_ONE;
    assign mage  = nege ? T_TWO - t_val : t_val - T_TWO;
    assign magf  = negf ? T_ONE - t_val : t_val - T_ONE;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) begin
                n_pe[i][j] = {32'b0, r_pt[32*i +: 32]} * {32'b0, r_m[ST_T+2].mage[32*j +: 32]};
                n_pf[i][j] = {32'b0, r_pt[32*i +: 32]} * {32'b0, r_m[ST_T+2].magf[32*j +: 32]};
            end
        end
    end

    assign z12 = {r_z, 4'b0} - {2'b0, r_z, 2'b0};
    assign epk = pack48(r_ez[159:64], r_m[ST_T+5].nege);

    always_ff @(posedge i_clk) begin
        r_e0 <= {32'b0, r_m[ST_T].job.eps} * {32'b0, t_val[31:0]};
        r_e1 <= {32'b0, r_m[ST_T].job.eps} * {32'b0, t_val[63:32]};
        r_pt <= {32'b0, r_e0} + {r_e1, 32'b0};
        r_pe <= n_pe;
        r_pf <= n_pf;
        for (int j = 0; j < 2; j++) begin
            r_re[j] <= {64'b0, r_pe[0][j]} + {32'b0, r_pe[1][j], 32'b0}
                     + {r_pe[2][j], 64'b0};
            r_rf[j] <= {64'b0, r_pf[0][j]} + {32'b0, r_pf[1][j], 32'b0}
                     + {r_pf[2][j], 64'b0};
        end
        r_ez <= {32'b0, r_re[0]} + {r_re[1], 32'b0};
        r_z  <= {32'b0, r_rf[0]} + {r_rf[1], 32'b0};
        r_y  <= z12[163:40];
    end

    // Force quotient by the root, one bit per stage; a high part at or above
    // the root means the quotient cannot fit and the force clips
    always_comb begin : fdiv_rows
        logic [31:0] rem_in, s_in;
        logic [47:0] low_in, q_in;
        logic [32:0] r2, sd;
        logic        ge, big_in;
        for (int k = 0; k < FDIV_STEPS; k++) begin
            s_in = r_m[ST_FDIV+k].s;
            if (k == 0) begin
                rem_in = r_y[79:48];
                low_in = r_y[47:0];
                q_in   = '0;
                big_in = (r_y[123:80] != '0) || (r_y[79:48] >= s_in);
            end else begin
                rem_in = r_frem[k-1];
                low_in = r_flow[k-1];
                q_in   = r_fq[k-1];
                big_in = r_fbig[k-1];
            end
            sd        = {1'b0, s_in};
            r2        = {rem_in, low_in[47]};
            ge        = r2 >= sd;
            n_frem[k] = ge ? 32'(r2 - sd) : r2[31:0];
            n_flow[k] = {low_in[46:0], 1'b0};
            n_fq[k]   = {q_in[46:0], ge};
            n_fbig[k] = big_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frem <= n_frem;
        r_flow <= n_flow;
        r_fq   <= n_fq;
        r_fbig <= n_fbig;
    end

    // Final selection by class
    assign fin = r_m[ST_LAST];
    assign fpk = pack48(r_fbig[FDIV_STEPS-1] ? '1 : {48'b0, r_fq[FDIV_STEPS-1]}, fin.negf);

    always_comb begin
        n_energy = '0;
        n_force  = '0;
        n_sat    = 1'b0;
        case (fin.job.cls)
            CLS_CUT: begin
                n_energy = '0;
            end
            CLS_ZERO: begin
                n_energy = POS_MAX;
                n_force  = fin.job.wf ? POS_MAX : '0;
                n_sat    = 1'b1;
            end
            CLS_NORM: begin
                if (fin.ovf) begin
                    if (fin.job.eps != '0) begin
                        n_energy = POS_MAX;
                        n_force  = fin.job.wf ? POS_MAX : '0;
                        n_sat    = 1'b1;
                    end
                end else begin
                    n_energy = fin.energy;
                    n_force  = fin.job.wf ? fpk.v : '0;
                    n_sat    = fin.esat || (fin.job.wf && fpk.sat);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_v[ST_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        o_energy      <= n_energy;
        o_force_res   <= n_force;
        o_force_valid <= fin.job.wf;
        o_saturated   <= n_sat;
    end

endmodule

[design/lcpef_checker.sv]
// Port-level checks for the pair energy/force unit, bound to the top level.
module lcpef_checker import lcpef_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    i_want_force,
    input logic                    o_done,
    input logic signed [OUT_W-1:0] o_force_res,
    input logic                    o_force_valid
);

    // the back end drains the queue every cycle, so it never fills
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue filled up");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_done)
        else $error("result missing at fixed latency");

    a_force_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY (o_force_valid == $past(i_want_force, LATENCY)))
        else $error("force_valid does not follow the request");

    a_force_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_force_valid |-> o_force_res == '0)
        else $error("force not zero when not requested");

endmodule

bind lj_cut_pair_energy_force_top lcpef_checker u_lcpef_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the Lennard-Jones cutoff pair energy and force unit.
module testbench import lcpef_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_WAIT     = LATENCY + 8;

    typedef struct {
        logic [OUT_W-1:0] energy;
        logic [OUT_W-1:0] force_res;
        logic             force_valid;
        logic             saturated;
    } t_pair_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_first_type = 1'b0;
    logic                    i_second_type = 1'b0;
    logic [DIST_W-1:0]       i_dist_sq = '0;
    logic                    i_want_force = 1'b0;
    logic                    o_done;
    logic signed [OUT_W-1:0] o_energy;
    logic signed [OUT_W-1:0] o_force_res;
    logic                    o_force_valid;
    logic                    o_saturated;

    lj_cut_pair_energy_force_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the parameter registers
    logic [CFG_W-1:0] shadow_regs [7];

    t_pair_result pending_results [$];
    int n_pairs, n_checked, n_errors, idle_cycles, burst_left;

    function automatic logic [63:0] root_q24(input logic [63:0] x);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            sq   = 128'(cand) * 128'(cand);
            if (sq <= 128'(x)) res = cand;
        end
        return res;
    endfunction

    // Clip to signed 48 bits; bit 48 flags the clip
    function automatic logic [OUT_W:0] clip48(input logic [191:0] m, input logic neg);
        logic [191:0]     lim;
        logic [OUT_W-1:0] v;
        logic             clipped;
        lim     = neg ? 192'h8000_0000_0000 : 192'h7FFF_FFFF_FFFF;
        clipped = m > lim;
        v       = clipped ? lim[OUT_W-1:0] : m[OUT_W-1:0];
        return {clipped, neg ? OUT_W'(~v + 1'b1) : v};
    endfunction

    function automatic t_pair_result lj_pair_predict(input logic ft, input logic st,
                                                     input logic [31:0] dq, input logic wf);
        t_pair_result r;
        logic [31:0]  eps;
        logic [39:0]  rm6;
        logic [95:0]  d3;
        logic [127:0] tq;
        logic [63:0]  t, mag, s;
        logic [191:0] prod;
        logic [OUT_W:0] pe, pf;
        r.energy = '0;
        r.force_res = '0;
        r.force_valid = wf;
        r.saturated = 1'b0;
        if (dq > shadow_regs[CFG_CUTOFF_SQ][31:0]) return r;
        case (2'(ft) + 2'(st))
            2'd0: begin eps = shadow_regs[CFG_EPS_AA][31:0]; rm6 = shadow_regs[CFG_RMSIX_AA]; end
            2'd1: begin eps = shadow_regs[CFG_EPS_AB][31:0]; rm6 = shadow_regs[CFG_RMSIX_AB]; end
            default: begin
                eps = shadow_regs[CFG_EPS_BB][31:0];
                rm6 = shadow_regs[CFG_RMSIX_BB];
            end
        endcase
        if (dq == 0) begin
            r.energy = POS_MAX;
            r.force_res = wf ? POS_MAX : '0;
            r.saturated = 1'b1;
            return r;
        end
        d3 = 96'(dq) * 96'(dq) * 96'(dq);
        if (96'(rm6) >= d3) begin
            if (eps != 0) begin
                r.energy = POS_MAX;
                r.force_res = wf ? POS_MAX : '0;
                r.saturated = 1'b1;
            end
            return r;
        end
        tq   = (128'(rm6) << 64) / 128'(d3);
        t    = tq[63:0];
        mag  = t >= T_TWO ? t - T_TWO : T_TWO - t;
        prod = 192'(eps) * 192'(t) * 192'(mag);
        pe   = clip48(prod >> 64, t < T_TWO);
        r.energy = pe[OUT_W-1:0];
        r.saturated = pe[OUT_W];
        if (wf) begin
            s    = root_q24(64'(dq) << 32);
            mag  = t >= T_ONE ? t - T_ONE : T_ONE - t;
            prod = 192'(eps) * 192'd12 * 192'(t) * 192'(mag);
            prod = (prod / 192'(s)) >> 40;
            pf   = clip48(prod, t < T_ONE);
            r.force_res = pf[OUT_W-1:0];
            r.saturated = r.saturated | pf[OUT_W];
        end
        return r;
    endfunction

    // Result checker: every strobed result must match the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_pair_result want;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_energy !== want.energy || o_force_res !== want.force_res ||
                    o_force_valid !== want.force_valid || o_saturated !== want.saturated) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d exp e=%h f=%h fv=%b sat=%b got e=%h f=%h fv=%b sat=%b",
                                 n_checked, want.energy, want.force_res, want.force_valid,
                                 want.saturated, o_energy, o_force_res, o_force_valid,
                                 o_saturated);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired with %0d results pending",
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_regs[idx] = (idx <= CFG_EPS_BB) ? {8'd0, data[31:0]} : data;
    endtask

    // Hold start low and wait until every expected result has come back
    task automatic drain_pipe();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic ft, input logic st,
                             input logic [31:0] dq, input logic wf);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 9);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 25);
        end
        burst_left--;
        @(negedge i_clk);
        start         <= 1'b1;
        i_first_type  <= ft;
        i_second_type <= st;
        i_dist_sq     <= dq;
        i_want_force  <= wf;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(lj_pair_predict(ft, st, dq, wf));
        n_pairs++;
    endtask

    function automatic logic [31:0] pick_dist();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 255);
            2: return $urandom_range(32'h0001_0000, 32'h0010_0000);
            default: return $urandom_range(32'h0000_6000, 32'h0003_0000);
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_dist(),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        logic [31:0] dists [8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000,
                                   32'h0001_1F5C, 32'h0000_8000, 32'h8000_0000,
                                   32'h0000_4000};
        foreach (dists[i]) send_pair(i[0], i[1], dists[i], i[2]);
        for (int k = 0; k < 4; k++) send_pair(k[0], k[1], 32'h0001_2000, 1'b1);
        drain_pipe();
        write_reg(CFG_CUTOFF_SQ, 40'h00_0002_0000);
        send_pair(1'b0, 1'b1, 32'h0002_0000, 1'b1);
        send_pair(1'b1, 1'b0, 32'h0002_0001, 1'b1);
        send_pair(1'b0, 1'b0, 32'h0002_0001, 1'b0);
        send_pair(1'b1, 1'b1, 32'h0000_0000, 1'b1);
        drain_pipe();
        write_reg(CFG_CUTOFF_SQ, 40'hFF_0000_0000);
        send_pair(1'b0, 1'b0, 32'h0000_0000, 1'b0);
        drain_pipe();
    endtask

    task automatic test_random_params(input int phases, input int per_phase);
        repeat (phases) begin
            write_reg(CFG_CUTOFF_SQ, ($urandom_range(0, 2) == 0) ? 40'hFF_FFFF_FFFF
                                                             : {8'd0, 32'($urandom())});
            write_reg(CFG_EPS_AA, {8'($urandom()), 32'($urandom_range(1, 32'h0008_0000))});
            write_reg(CFG_EPS_AB, {8'($urandom()), 32'($urandom())});
            write_reg(CFG_EPS_BB, {8'($urandom()), 32'($urandom_range(0, 32'h0004_0000))});
            write_reg(CFG_RMSIX_AA, 40'($urandom_range(32'h0000_4000, 32'h0040_0000)));
            write_reg(CFG_RMSIX_AB, {8'($urandom()), 32'($urandom())});
            write_reg(CFG_RMSIX_BB, 40'($urandom_range(32'h0001_0000, 32'h0008_0000)));
            send_random(per_phase);
            drain_pipe();
        end
    endtask

    task automatic test_extremes();
        write_reg(CFG_EPS_AA, 40'hFF_FFFF_FFFF);
        write_reg(CFG_EPS_AB, 40'h00_0000_0000);
        write_reg(CFG_EPS_BB, 40'h00_0001_0000);
        write_reg(CFG_RMSIX_AA, 40'hFF_FFFF_FFFF);
        write_reg(CFG_RMSIX_AB, 40'hFF_FFFF_FFFF);
        write_reg(CFG_RMSIX_BB, 40'h00_0000_0000);
        write_reg(CFG_CUTOFF_SQ, 40'h00_FFFF_FFFF);
        send_random(150);
        drain_pipe();
        write_reg(CFG_CUTOFF_SQ, 40'h00_0000_0000);
        write_reg(CFG_RMSIX_AA, 40'h00_0000_0001);
        write_reg(CFG_EPS_AB, 40'h00_FFFF_FFFF);
        send_random(100);
        drain_pipe();
    endtask

    initial begin
        for (int i = 0; i < 7; i++) shadow_regs[i] = 40'h00_0001_0000;
        shadow_regs[CFG_CUTOFF_SQ] = 40'h00_FFFF_FFFF;
        n_pairs = 0;
        n_checked = 0;
        n_errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        send_random(400);
        drain_pipe();
        test_random_params(6, 200);
        test_extremes();

        $display("Covered %0d pairs, %0d results checked, over default, random and extreme",
                 n_pairs, n_checked);
        $display("parameter settings with cutoff, zero-distance and ratio-overflow cases.");
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, pending_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
design/lcpef_pkg.sv
design/lcpef_front.sv
design/lcpef_fifo.sv
design/lcpef_back.sv
design/lj_cut_pair_energy_force_top.sv
design/lcpef_checker.sv
tb/testbench.sv
